FILE: design/solar_day_night_controller_top_assert.svh
// Assertion macros used by the controller checker.
`ifndef SOLAR_DAY_NIGHT_CONTROLLER_TOP_ASSERT_SVH
`define SOLAR_DAY_NIGHT_CONTROLLER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SDNC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("controller check failed");

// Consequent must hold in the cycle after the antecedent.
`define SDNC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("controller check failed");

`endif

FILE: design/sdnc_pkg.sv
package sdnc_pkg;

  // ADC and compare widths
  localparam int AdcBits = 10;
  localparam int SumBits = AdcBits + 1;

  // configuration register indexes
  localparam logic [1:0] REG_DAWN_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_DUSK_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_DIODE_ON_MARGIN  = 2'd2;
  localparam logic [1:0] REG_DIODE_OFF_MARGIN = 2'd3;

  // mode codes as reported
  localparam logic [1:0] MODE_BOOT  = 2'd0;
  localparam logic [1:0] MODE_NIGHT = 2'd1;
  localparam logic [1:0] MODE_TRANS = 2'd2;
  localparam logic [1:0] MODE_DAY   = 2'd3;

  // LED driver commands
  localparam logic [1:0] CMD_KEEP  = 2'd0;
  localparam logic [1:0] CMD_OFF   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // LED driver status codes
  localparam logic [1:0] LED_OFF       = 2'd0;
  localparam logic [1:0] LED_STS_FAULT = 2'd2;

  // tick limits
  localparam logic signed [5:0] DawnLimit    = 6'sd20;
  localparam logic signed [5:0] DuskLimit    = -6'sd20;
  localparam logic signed [6:0] DayOnLimit   = 7'sd50;
  localparam logic signed [6:0] DayOffLimit  = -7'sd5;
  localparam logic [4:0]        OffsetLast   = 5'd29;
  localparam logic [10:0]       FaultSat     = 11'd1001;
  localparam logic [10:0]       FaultLimit   = 11'd1000;
  localparam logic [SumBits-1:0] IndMargin   = 11'd4;

  // controller state, one-hot
  typedef enum logic [3:0] {
    ST_BOOT  = 4'b0001,
    ST_NIGHT = 4'b0010,
    ST_TRANS = 4'b0100,
    ST_DAY   = 4'b1000
  } state_e;

  typedef struct packed {
    logic [AdcBits-1:0] panel_voltage;
    logic [AdcBits-1:0] charge_current;
    logic               low_battery;
    logic [1:0]         led_status;
  } in_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       diode_enable;
    logic       charger_enable;
    logic       charge_indicator;
    logic [1:0] led_command;
  } out_t;

endpackage

FILE: design/solar_day_night_controller_top.sv
// Path: each input transaction is held in the input register, then its result in the result
// register; both hold while the output side stalls.
// Throughput: one transaction per cycle while the output side does not stall; the state update
// is a single compare-and-count pass between the input register and the result register.
// Reset (rst_ni low, asynchronous): boot mode, all counters, flags and thresholds zero,
// both pipeline stages empty.
module solar_day_night_controller_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  sdnc_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output sdnc_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [sdnc_pkg::AdcBits-1:0]     cfg_wdata_i
);

  // configuration
  logic [sdnc_pkg::AdcBits-1:0] dawn_thr_q, dusk_thr_q, on_margin_q, off_margin_q;

  // pipeline
  logic           in_vld_q, out_vld_q, adv;
  sdnc_pkg::in_t  in_q;
  sdnc_pkg::out_t out_q, res_d;

  // controller state
  sdnc_pkg::state_e st_q, st_d;
  logic                         body_q, body_d;
  logic signed [5:0]            ddc_q, ddc_d;
  logic signed [6:0]            dayc_q, dayc_d;
  logic [4:0]                   ow_q, ow_d;
  logic                         need_q, need_d;
  logic [sdnc_pkg::AdcBits-1:0] off_q, off_d;
  logic [10:0]                  fw_q, fw_d;
  logic                         diode_q, diode_d, chg_q, chg_d, ind_q, ind_d;
  logic [1:0]                   cmd;

  // compares, one bit wider than the ADC
  logic [sdnc_pkg::SumBits-1:0] cc_w, on_sum, off_sum, ind_sum;
  logic                         dawn_hit, dusk_hit, on_hit, off_hit, ind_hit;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign cc_w    = {1'b0, in_q.charge_current};
  assign on_sum  = {1'b0, off_q} + {1'b0, on_margin_q};
  assign off_sum = {1'b0, off_q} + {1'b0, off_margin_q};
  assign ind_sum = {1'b0, off_q} + sdnc_pkg::IndMargin;

  assign dawn_hit = in_q.panel_voltage > dawn_thr_q;
  assign dusk_hit = in_q.panel_voltage < dusk_thr_q;
  assign on_hit   = cc_w >= on_sum;
  assign off_hit  = cc_w <= off_sum;
  assign ind_hit  = cc_w >= ind_sum;

  // next state for the transaction in the input register
  always_comb begin
    st_d    = st_q;
    body_d  = body_q;
    ddc_d   = ddc_q;
    dayc_d  = dayc_q;
    ow_d    = ow_q;
    need_d  = need_q;
    off_d   = off_q;
    fw_d    = fw_q;
    diode_d = diode_q;
    chg_d   = chg_q;
    ind_d   = ind_q;
    cmd     = sdnc_pkg::CMD_KEEP;
    unique case (st_q)
      sdnc_pkg::ST_BOOT: begin
        st_d   = sdnc_pkg::ST_NIGHT;
        body_d = 1'b0;
      end
      sdnc_pkg::ST_NIGHT: begin
        if (!body_q) begin
          body_d  = 1'b1;
          diode_d = 1'b0;
          ind_d   = 1'b0;
        end else if (dawn_hit && ddc_q >= sdnc_pkg::DawnLimit) begin
          // dawn confirmed: leave night, command the LEDs off, normal LED logic skipped
          body_d = 1'b0;
          st_d   = sdnc_pkg::ST_TRANS;
          need_d = 1'b1;
          ow_d   = '0;
          cmd    = sdnc_pkg::CMD_OFF;
        end else begin
          ddc_d = dawn_hit ? ddc_q + 6'sd1 : 6'sd0;
          if (in_q.low_battery) begin
            if (in_q.led_status != sdnc_pkg::LED_STS_FAULT) cmd = sdnc_pkg::CMD_OFF;
          end else begin
            if (in_q.led_status == sdnc_pkg::LED_OFF) cmd = sdnc_pkg::CMD_START;
            if (in_q.led_status == sdnc_pkg::LED_STS_FAULT) begin
              // fault wait saturates; force off once it runs out
              if (fw_q < sdnc_pkg::FaultSat) fw_d = fw_q + 11'd1;
              if (fw_q >= sdnc_pkg::FaultLimit) cmd = sdnc_pkg::CMD_OFF;
            end else begin
              fw_d = '0;
            end
          end
        end
      end
      sdnc_pkg::ST_TRANS: begin
        if (!body_q) begin
          diode_d = 1'b0;
          if (need_q && ow_q < sdnc_pkg::OffsetLast) begin
            ow_d = ow_q + 5'd1;
          end else begin
            if (need_q) begin
              // settle time over: capture the current offset
              ow_d   = '0;
              off_d  = in_q.charge_current;
              need_d = 1'b0;
            end
            chg_d  = 1'b1;
            body_d = 1'b1;
          end
        end else if (dusk_hit && ddc_q <= sdnc_pkg::DuskLimit) begin
          body_d = 1'b0;
          st_d   = sdnc_pkg::ST_NIGHT;
          chg_d  = 1'b0;
        end else begin
          ddc_d = dusk_hit ? ddc_q - 6'sd1 : 6'sd0;
          if (on_hit && dayc_q >= sdnc_pkg::DayOnLimit) begin
            body_d  = 1'b0;
            st_d    = sdnc_pkg::ST_DAY;
            diode_d = 1'b1;
          end else begin
            dayc_d = on_hit ? dayc_q + 7'sd1 : 7'sd0;
            ind_d  = ind_hit;
          end
        end
      end
      sdnc_pkg::ST_DAY: begin
        if (!body_q) begin
          dayc_d = '0;
          body_d = 1'b1;
          ind_d  = 1'b1;
        end else if (off_hit) begin
          if (dayc_q <= sdnc_pkg::DayOffLimit) begin
            diode_d = 1'b0;
            body_d  = 1'b0;
            st_d    = sdnc_pkg::ST_TRANS;
            dayc_d  = '0;
          end else begin
            dayc_d = dayc_q - 7'sd1;
          end
        end else begin
          dayc_d = '0;
        end
      end
      default: begin
        st_d   = sdnc_pkg::ST_BOOT;
        body_d = 1'b0;
      end
    endcase
  end

  // result encoding
  always_comb begin
    unique case (st_d)
      sdnc_pkg::ST_NIGHT: res_d.mode = sdnc_pkg::MODE_NIGHT;
      sdnc_pkg::ST_TRANS: res_d.mode = sdnc_pkg::MODE_TRANS;
      sdnc_pkg::ST_DAY:   res_d.mode = sdnc_pkg::MODE_DAY;
      default:            res_d.mode = sdnc_pkg::MODE_BOOT;
    endcase
    res_d.diode_enable     = diode_d;
    res_d.charger_enable   = chg_d;
    res_d.charge_indicator = ind_d;
    res_d.led_command      = cmd;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dawn_thr_q   <= '0;
      dusk_thr_q   <= '0;
      on_margin_q  <= '0;
      off_margin_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdnc_pkg::REG_DAWN_THRESHOLD:   dawn_thr_q   <= cfg_wdata_i;
        sdnc_pkg::REG_DUSK_THRESHOLD:   dusk_thr_q   <= cfg_wdata_i;
        sdnc_pkg::REG_DIODE_ON_MARGIN:  on_margin_q  <= cfg_wdata_i;
        sdnc_pkg::REG_DIODE_OFF_MARGIN: off_margin_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (adv) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
    if (adv) out_q <= res_d;
  end

  // controller state, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= sdnc_pkg::ST_BOOT;
      body_q  <= 1'b0;
      ddc_q   <= '0;
      dayc_q  <= '0;
      ow_q    <= '0;
      need_q  <= 1'b0;
      off_q   <= '0;
      fw_q    <= '0;
      diode_q <= 1'b0;
      chg_q   <= 1'b0;
      ind_q   <= 1'b0;
    end else if (adv) begin
      st_q    <= st_d;
      body_q  <= body_d;
      ddc_q   <= ddc_d;
      dayc_q  <= dayc_d;
      ow_q    <= ow_d;
      need_q  <= need_d;
      off_q   <= off_d;
      fw_q    <= fw_d;
      diode_q <= diode_d;
      chg_q   <= chg_d;
      ind_q   <= ind_d;
    end
  end

endmodule

FILE: design/sdnc_checker.sv
`include "solar_day_night_controller_top_assert.svh"

module sdnc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input sdnc_pkg::in_t                in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input sdnc_pkg::out_t               out_data_o
);

  logic in_hold;
  logic out_hold;

  assign in_hold  = in_valid_i && in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;

  // a stalled input transaction stays in place
  `SDNC_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_hold, in_valid_i && $stable(in_data_i))

  // a stalled result stays in place
  `SDNC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold,
                    out_valid_o && $stable(out_data_o))

  // boot mode is left on the first transaction, so it never shows
  `SDNC_ASSERT_NOW(a_no_boot, clk_i, rst_ni, out_valid_o,
                   out_data_o.mode != sdnc_pkg::MODE_BOOT)

  // the bypass diode is on exactly in day mode
  `SDNC_ASSERT_NOW(a_diode_day, clk_i, rst_ni, out_valid_o,
                   out_data_o.diode_enable == (out_data_o.mode == sdnc_pkg::MODE_DAY))

  // charger is off in night; LEDs are started only in night
  `SDNC_ASSERT_NOW(a_night_outputs, clk_i, rst_ni,
                   out_valid_o && (out_data_o.charger_enable ||
                   out_data_o.led_command == sdnc_pkg::CMD_START),
                   (out_data_o.mode == sdnc_pkg::MODE_NIGHT) != out_data_o.charger_enable)

endmodule

bind solar_day_night_controller_top sdnc_checker u_sdnc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
